// ===== hw/rtl/spectral_band_gate_trigger_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SPECTRAL_BAND_GATE_TRIGGER_DEFINES_SVH
`define SPECTRAL_BAND_GATE_TRIGGER_DEFINES_SVH

// Implication checked in the same cycle, masked during reset.
`define SBGT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sbgt assertion failed");

// Implication checked in the next cycle, masked during reset.
`define SBGT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sbgt assertion failed");

// Implication checked in the next cycle, active during reset as well.
`define SBGT_ASSERT_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("sbgt reset assertion failed");

`endif

// ===== hw/rtl/sbgt_pkg.sv =====
package sbgt_pkg;

  localparam int unsigned HALF_BINS       = 1024;
  localparam int unsigned TRIGGER_SAMPLES = 48;

  localparam int unsigned NUM_BANDS = 4;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned BIN_W     = 11;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [15:0]      HALF_BINS_C = 16'(HALF_BINS);
  localparam logic [CNT_W-1:0] TRIG_LOAD_C = CNT_W'(TRIGGER_SAMPLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_SUB  = 4'd0,
    CFG_THRESHOLD_BASS = 4'd1,
    CFG_THRESHOLD_MID  = 4'd2,
    CFG_THRESHOLD_HIGH = 4'd3,
    CFG_EDGE_BIN_SUB   = 4'd4,
    CFG_EDGE_BIN_BASS  = 4'd5,
    CFG_EDGE_BIN_MID   = 4'd6,
    CFG_EDGE_BIN_HIGH  = 4'd7
  } cfg_reg_t;

  localparam logic OP_BIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             op;
    logic [BIN_W-1:0] bin_index;
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } in_item_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0] gate_bits;
    logic [NUM_BANDS-1:0] trigger_bits;
  } out_item_t;

endpackage

// ===== hw/rtl/spectral_band_gate_trigger.sv =====
// Spectral band gate and trigger generator.
// Input channel (in_valid/in_ready/in_item): spectrum bins with op = bin,
// in rising bin order, and audio sample ticks with op = tick. Bin items
// update the four band peaks; the item flagged last_bin updates the gates
// and starts a countdown for every rising gate. Each tick produces one
// result item on the output channel (out_valid/out_ready/out_item) with the
// gate bits and trigger bits, then counts the running triggers down.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while no items are in flight.
// Throughput: one item per cycle while no tick waits behind a held result.
// A tick's result passes the input register, then the result register.
// When the receiver stalls, the held result stays put; one more item can
// sit in the input register, and a bin item still drains through it, so
// in_ready drops only when a tick is waiting behind a held result.
// Reset (rst_n low, synchronous) empties both registers, clears peaks,
// gates and countdowns, and restores default thresholds and edge bins.
module spectral_band_gate_trigger
  import sbgt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [MAG_W-1:0] thr_r  [NUM_BANDS];
  logic [BIN_W-1:0] edge_r [NUM_BANDS];

  in_item_t         stg_r;
  logic             stg_valid_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic [MAG_W-1:0]     peak_r, peak_nxt;
  logic [2:0]           band_r, band_nxt;
  logic [NUM_BANDS-1:0] above_r, above_nxt;
  logic [NUM_BANDS-1:0] gate_r, gate_nxt;
  logic [CNT_W-1:0]     cnt_r [NUM_BANDS];
  logic [CNT_W-1:0]     cnt_nxt [NUM_BANDS];
  logic [NUM_BANDS-1:0] trig_now;

  logic stg_adv;
  logic stg_tick;
  logic in_range;
  logic close_band;
  logic [1:0]       band_sel;
  logic [MAG_W-1:0] peak_base;

  assign cfg_ready = 1'b1;
  assign stg_tick  = stg_r.op == OP_TICK;
  assign stg_adv   = stg_valid_r && (!stg_tick || !out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || stg_adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign band_sel = band_r[1:0];
  assign in_range = (stg_r.bin_index != '0)
                 && ({{(16-BIN_W){1'b0}}, stg_r.bin_index} <= HALF_BINS_C)
                 && !band_r[2];
  assign close_band = in_range && (stg_r.bin_index > edge_r[band_sel]);
  assign peak_base  = close_band ? '0 : peak_r;

  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      trig_now[b] = cnt_r[b] != '0;
    end
  end

  always_comb begin
    peak_nxt  = peak_r;
    band_nxt  = band_r;
    above_nxt = above_r;
    gate_nxt  = gate_r;
    cnt_nxt   = cnt_r;
    if (stg_adv) begin
      if (stg_tick) begin
        for (int b = 0; b < NUM_BANDS; b++) begin
          if (trig_now[b]) begin
            cnt_nxt[b] = cnt_r[b] - CNT_W'(1);
          end
        end
      end else begin
        if (close_band) begin
          if (peak_r > thr_r[band_sel]) begin
            above_nxt[band_sel] = 1'b1;
          end
          band_nxt = band_r + 3'd1;
        end
        peak_nxt = peak_base;
        if (in_range && !band_nxt[2] && (stg_r.magnitude > peak_base)) begin
          peak_nxt = stg_r.magnitude;
        end
        if (stg_r.last_bin) begin
          for (int b = 0; b < NUM_BANDS; b++) begin
            if (above_nxt[b] && !gate_r[b]) begin
              cnt_nxt[b] = TRIG_LOAD_C;
            end
          end
          gate_nxt  = above_nxt;
          peak_nxt  = '0;
          band_nxt  = '0;
          above_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      band_r      <= '0;
      above_r     <= '0;
      gate_r      <= '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        cnt_r[b] <= '0;
        thr_r[b] <= '0;
      end
      edge_r[0] <= BIN_W'(1);
      edge_r[1] <= BIN_W'(5);
      edge_r[2] <= BIN_W'(42);
      edge_r[3] <= BIN_W'(170);
    end else begin
      peak_r  <= peak_nxt;
      band_r  <= band_nxt;
      above_r <= above_nxt;
      gate_r  <= gate_nxt;
      cnt_r   <= cnt_nxt;

      if (in_valid && in_ready) begin
        stg_r       <= in_item;
        stg_valid_r <= 1'b1;
      end else if (stg_adv) begin
        stg_valid_r <= 1'b0;
      end

      if (stg_adv && stg_tick) begin
        out_r.gate_bits    <= gate_r;
        out_r.trigger_bits <= trig_now;
        out_valid_r        <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD_SUB:  thr_r[0]  <= cfg_data;
          CFG_THRESHOLD_BASS: thr_r[1]  <= cfg_data;
          CFG_THRESHOLD_MID:  thr_r[2]  <= cfg_data;
          CFG_THRESHOLD_HIGH: thr_r[3]  <= cfg_data;
          CFG_EDGE_BIN_SUB:   edge_r[0] <= cfg_data[BIN_W-1:0];
          CFG_EDGE_BIN_BASS:  edge_r[1] <= cfg_data[BIN_W-1:0];
          CFG_EDGE_BIN_MID:   edge_r[2] <= cfg_data[BIN_W-1:0];
          CFG_EDGE_BIN_HIGH:  edge_r[3] <= cfg_data[BIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/sbgt_checker.sv =====
`include "spectral_band_gate_trigger_defines.svh"

module sbgt_checker
  import sbgt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input in_item_t             in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_item_t            out_item
);

  logic in_tick_acc;
  assign in_tick_acc = in_valid && in_ready && (in_item.op == OP_TICK);

  // reset leaves no result pending
  `SBGT_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // a fresh result traces back to an accepted tick that passed the input register
  `SBGT_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_tick_acc, 2))

  // with the result slot empty, input is never refused
  `SBGT_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // held result keeps its value
  `SBGT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind spectral_band_gate_trigger sbgt_checker u_sbgt_checker (.*);

// ===== sim/spectral_band_gate_trigger_tb.sv =====
module spectral_band_gate_trigger_tb
  import sbgt_pkg::*;
();

  localparam int NUM_CFG_REGS = int'(CFG_EDGE_BIN_HIGH) + 1;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [BIN_W-1:0] BIN_MAX = '1;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // band tracker shadow
  logic [MAG_W-1:0]     thr_m [NUM_BANDS];
  logic [BIN_W-1:0]     edge_bin_m [NUM_BANDS];
  logic [MAG_W-1:0]     peak_m;
  logic [2:0]           band_m;
  logic [NUM_BANDS-1:0] above_m;
  logic [NUM_BANDS-1:0] gate_m;
  logic [CNT_W-1:0]     countdown_m [NUM_BANDS];

  out_item_t pending_status[$];

  int errors       = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int frames_ended = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int cfg_settings = 0;
  int burst_left   = 0;
  int hold_req     = 0;
  int frame_bin    = 0;
  int frame_left   = 0;
  int frame_step   = 1;

  spectral_band_gate_trigger i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic reset_band_model();
    for (int b = 0; b < NUM_BANDS; b++) begin
      thr_m[b]       = '0;
      countdown_m[b] = '0;
    end
    edge_bin_m[0] = BIN_W'(1);
    edge_bin_m[1] = BIN_W'(5);
    edge_bin_m[2] = BIN_W'(42);
    edge_bin_m[3] = BIN_W'(170);
    peak_m  = '0;
    band_m  = '0;
    above_m = '0;
    gate_m  = '0;
  endtask

  task automatic predict_band_gate(input in_item_t it);
    logic [NUM_BANDS-1:0] running;
    out_item_t            st;
    running = '0;
    if (it.op == OP_TICK) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        running[b] = (countdown_m[b] != '0);
        if (running[b]) countdown_m[b] = countdown_m[b] - 1'b1;
      end
      st.gate_bits    = gate_m;
      st.trigger_bits = running;
      pending_status.insert(pending_status.size(), st);
      ticks_sent++;
    end else begin
      if (it.bin_index >= 1 && it.bin_index <= HALF_BINS && band_m < NUM_BANDS) begin
        if (it.bin_index > edge_bin_m[band_m[1:0]]) begin
          if (peak_m > thr_m[band_m[1:0]]) above_m[band_m[1:0]] = 1'b1;
          band_m = band_m + 1'b1;
          peak_m = '0;
        end
        if (band_m < NUM_BANDS && it.magnitude > peak_m) peak_m = it.magnitude;
      end
      if (it.last_bin) begin
        for (int b = 0; b < NUM_BANDS; b++)
          if (above_m[b] && !gate_m[b]) countdown_m[b] = TRIG_LOAD_C;
        gate_m  = above_m;
        peak_m  = '0;
        band_m  = '0;
        above_m = '0;
        frames_ended++;
      end
    end
  endtask

  function automatic in_item_t bin_item(input logic [BIN_W-1:0] bin,
                                        input logic [MAG_W-1:0] mag, input logic last);
    in_item_t it;
    it.op        = OP_BIN;
    it.bin_index = bin;
    it.magnitude = mag;
    it.last_bin  = last;
    return it;
  endfunction

  // unused fields carry noise
  function automatic in_item_t tick_item();
    in_item_t it;
    it.op        = OP_TICK;
    it.bin_index = BIN_W'($urandom);
    it.magnitude = $urandom;
    it.last_bin  = 1'($urandom);
    return it;
  endfunction

  function automatic logic [MAG_W-1:0] pick_magnitude(input logic [MAG_W-1:0] span);
    logic [MAG_W-1:0] t;
    t = thr_m[$urandom_range(0, NUM_BANDS - 1)];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MAG_MAX;
      2: return t;
      3: return t + 1'b1;
      4: return t - 1'b1;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    predict_band_gate(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    // bin items leave no result but may still be in the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cfg(input logic [NUM_BANDS-1:0][MAG_W-1:0] thr,
                          input logic [NUM_BANDS-1:0][BIN_W-1:0] edg);
    cfg_reg_t             r;
    logic [CFG_DAT_W-1:0] data;
    for (int k = 0; k < NUM_CFG_REGS; k++) begin
      r    = cfg_reg_t'(k);
      data = $urandom;
      if (k < NUM_BANDS) data = thr[k];
      else data[BIN_W-1:0] = edg[k - NUM_BANDS];
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      if (k < NUM_BANDS) thr_m[k] = thr[k];
      else edge_bin_m[k - NUM_BANDS] = edg[k - NUM_BANDS];
      cfg_writes++;
    end
    // index past the register map: must be dropped
    cfg_index <= CFG_IDX_W'(NUM_CFG_REGS +
                 $urandom_range(0, (1 << CFG_IDX_W) - 1 - NUM_CFG_REGS));
    cfg_data  <= $urandom;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_settings++;
  endtask

  task automatic run_traffic(input int n, input int tick_pct, input logic [MAG_W-1:0] span);
    in_item_t it;
    repeat (n) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        it = tick_item();
      end else begin
        if (frame_left == 0) begin
          frame_left = $urandom_range(1, 16);
          frame_bin  = $urandom_range(0, 3);
          frame_step = 1 << $urandom_range(0, 8);
        end
        if ($urandom_range(0, 9) == 0) begin
          it = bin_item(BIN_W'($urandom), pick_magnitude(span), $urandom_range(0, 3) == 0);
        end else begin
          it = bin_item(BIN_W'(frame_bin), pick_magnitude(span),
                        frame_left == 1 && $urandom_range(0, 7) != 0);
          frame_bin = frame_bin + $urandom_range(1, frame_step);
          if (frame_bin > int'(BIN_MAX)) frame_bin = int'(BIN_MAX);
        end
        frame_left--;
      end
      send_item(it);
    end
  endtask

  task automatic test_reset_state();
    send_item(tick_item());
  endtask

  task automatic test_band_closing();
    send_item(bin_item(BIN_W'(0), MAG_MAX, 1'b0));
    send_item(bin_item(BIN_W'(1), '0, 1'b0));
    send_item(bin_item(BIN_W'(2), MAG_W'(1), 1'b0));
    send_item(bin_item(BIN_W'(6), MAG_MAX, 1'b0));
    send_item(bin_item(BIN_W'(43), MAG_W'(5), 1'b0));
    send_item(bin_item(BIN_W'(171), MAG_W'(7), 1'b0));
    send_item(bin_item(BIN_W'(HALF_BINS), MAG_MAX, 1'b1));
    repeat (2) send_item(tick_item());
  endtask

  task automatic test_bin_zero_and_retrigger();
    send_item(bin_item(BIN_W'(0), MAG_MAX, 1'b1));
    send_item(tick_item());
    // band 1 rises again while its countdown is still running
    send_item(bin_item(BIN_W'(2), MAG_W'(3), 1'b0));
    send_item(bin_item(BIN_W'(6), '0, 1'b1));
    send_item(tick_item());
  endtask

  task automatic test_out_of_order_bins();
    send_item(bin_item(BIN_W'(50), MAG_W'(2), 1'b0));
    send_item(bin_item(BIN_W'(3), MAG_W'(100), 1'b0));
    send_item(bin_item(BIN_W'(HALF_BINS + 1), MAG_MAX, 1'b0));
    send_item(bin_item(BIN_MAX, MAG_MAX, 1'b1));
    send_item(tick_item());
  endtask

  task automatic test_random_settings();
    logic [NUM_BANDS-1:0][MAG_W-1:0] thr;
    logic [NUM_BANDS-1:0][BIN_W-1:0] edg;
    int e;
    for (int s = 0; s < 6; s++) begin
      e = $urandom_range(0, 8);
      for (int b = 0; b < NUM_BANDS; b++) begin
        thr[b] = $urandom_range(0, 1000);
        edg[b] = BIN_W'(e);
        e = e + $urandom_range(1, 80);
      end
      case (s)
        1: begin
          thr = '0;
          edg = '0;
        end
        2: begin
          thr = '1;
          edg = '1;
        end
        3: begin
          thr = {$urandom, $urandom, MAG_MAX, MAG_W'(0)};
          edg = {BIN_MAX, BIN_W'(HALF_BINS), BIN_W'(HALF_BINS - 1), BIN_W'(0)};
        end
        4: for (int b = 0; b < NUM_BANDS; b++) edg[b] = BIN_W'($urandom);
        default: ;
      endcase
      wait_idle();
      load_cfg(thr, edg);
      case (s)
        3: run_traffic(80, 50, MAG_MAX);
        5: run_traffic(130, 85, MAG_W'(2000));
        default: run_traffic(75, 50, MAG_W'(2000));
      endcase
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 200;
    repeat (40) send_item(tick_item());
  endtask

  initial begin : receiver
    int       hold_cnt;
    int       mode_left;
    int       phase;
    rx_mode_t mode;
    hold_cnt  = 0;
    mode_left = 0;
    phase     = 0;
    mode      = RX_ALWAYS;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom);
          RX_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
          default:   out_ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : status_check
    out_item_t exp_st;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        $display("%0t: result with none expected: actual %h", $time, out_item);
        errors++;
      end else begin
        exp_st = pending_status.pop_front();
        if (out_item.gate_bits !== exp_st.gate_bits) begin
          $display("%0t: gate_bits expected %h, actual %h",
                   $time, exp_st.gate_bits, out_item.gate_bits);
          errors++;
        end
        if (out_item.trigger_bits !== exp_st.trigger_bits) begin
          $display("%0t: trigger_bits expected %h, actual %h",
                   $time, exp_st.trigger_bits, out_item.trigger_bits);
          errors++;
        end
      end
    end
  end

  initial begin : main_seq
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_band_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_band_closing();
    test_bin_zero_and_retrigger();
    test_out_of_order_bins();
    test_random_settings();
    test_backpressure();
    wait_idle();

    $display("Sent %0d items (%0d ticks, %0d frames ended), checked %0d results.",
             items_sent, ticks_sent, frames_ended, results_seen);
    $display("Wrote %0d registers across %0d settings, with a long output stall.",
             cfg_writes, cfg_settings);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
